// ----- rtl/mtp_pkg.sv -----
// Shared types, tag codes and sized-lead decode tables for the MessagePack
// tag header parser. No dependencies.
package mtp_pkg;

    // Input operation codes
    localparam logic [1:0] OP_DATA    = 2'd0;
    localparam logic [1:0] OP_END     = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // Tag type codes
    localparam logic [3:0] TT_UNKNOWN = 4'd0;
    localparam logic [3:0] TT_NIL     = 4'd1;
    localparam logic [3:0] TT_BOOL    = 4'd2;
    localparam logic [3:0] TT_UINT    = 4'd3;
    localparam logic [3:0] TT_INT     = 4'd4;
    localparam logic [3:0] TT_F32     = 4'd5;
    localparam logic [3:0] TT_F64     = 4'd6;
    localparam logic [3:0] TT_STR     = 4'd7;
    localparam logic [3:0] TT_BIN     = 4'd8;
    localparam logic [3:0] TT_ARRAY   = 4'd9;
    localparam logic [3:0] TT_MAP     = 4'd10;
    localparam logic [3:0] TT_EXT     = 4'd11;

    // Lead byte values and masks
    localparam logic [7:0] LEAD_POS_MAX  = 8'h7f;
    localparam logic [7:0] LEAD_NEG_MIN  = 8'he0;
    localparam logic [7:0] LEAD_FIX_MASK = 8'hf0;
    localparam logic [7:0] LEAD_FIXMAP   = 8'h80;
    localparam logic [7:0] LEAD_FIXARR   = 8'h90;
    localparam logic [7:0] LEAD_STR_MASK = 8'he0;
    localparam logic [7:0] LEAD_FIXSTR   = 8'ha0;
    localparam logic [7:0] LEAD_NIL      = 8'hc0;
    localparam logic [7:0] LEAD_INVALID  = 8'hc1;
    localparam logic [7:0] LEAD_FALSE    = 8'hc2;
    localparam logic [7:0] LEAD_TRUE     = 8'hc3;
    localparam logic [7:0] LEAD_SIZED    = 8'hc4;
    localparam logic [7:0] MASK_LO5      = 8'h1f;
    localparam logic [7:0] MASK_LO4      = 8'h0f;
    localparam int unsigned SIZED_COUNT  = 28;

    // Default depth of the queue between front and back
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    // Classified word handed from front to back
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
        logic       imm;       // lead gives an immediate tag
        logic       bad;       // invalid lead byte
        logic       sized;     // lead starts a sized header
        logic [3:0] imm_type;
        logic [7:0] imm_val;
        logic       imm_neg;   // negative fixint, sign-extend imm_val
    } cls_t;

    // Sized lead table entry
    typedef struct packed {
        logic [4:0] total;     // trailing bytes
        logic [3:0] vbytes;    // bytes that go into the value
        logic [3:0] ttype;
        logic [4:0] fixed;     // fixext payload length
    } sized_t;

    function automatic sized_t sized_info(input logic [4:0] idx);
        sized_t s;
        s = '{total: 5'd0, vbytes: 4'd0, ttype: TT_UNKNOWN, fixed: 5'd0};
        unique case (idx)
            5'd0:  s = '{5'd1,  4'd1, TT_BIN,   5'd0};
            5'd1:  s = '{5'd2,  4'd2, TT_BIN,   5'd0};
            5'd2:  s = '{5'd4,  4'd4, TT_BIN,   5'd0};
            5'd3:  s = '{5'd2,  4'd1, TT_EXT,   5'd0};
            5'd4:  s = '{5'd3,  4'd2, TT_EXT,   5'd0};
            5'd5:  s = '{5'd5,  4'd4, TT_EXT,   5'd0};
            5'd6:  s = '{5'd4,  4'd4, TT_F32,   5'd0};
            5'd7:  s = '{5'd8,  4'd8, TT_F64,   5'd0};
            5'd8:  s = '{5'd1,  4'd1, TT_UINT,  5'd0};
            5'd9:  s = '{5'd2,  4'd2, TT_UINT,  5'd0};
            5'd10: s = '{5'd4,  4'd4, TT_UINT,  5'd0};
            5'd11: s = '{5'd8,  4'd8, TT_UINT,  5'd0};
            5'd12: s = '{5'd1,  4'd1, TT_INT,   5'd0};
            5'd13: s = '{5'd2,  4'd2, TT_INT,   5'd0};
            5'd14: s = '{5'd4,  4'd4, TT_INT,   5'd0};
            5'd15: s = '{5'd8,  4'd8, TT_INT,   5'd0};
            5'd16: s = '{5'd2,  4'd0, TT_EXT,   5'd1};
            5'd17: s = '{5'd3,  4'd0, TT_EXT,   5'd2};
            5'd18: s = '{5'd5,  4'd0, TT_EXT,   5'd4};
            5'd19: s = '{5'd9,  4'd0, TT_EXT,   5'd8};
            5'd20: s = '{5'd17, 4'd0, TT_EXT,   5'd16};
            5'd21: s = '{5'd1,  4'd1, TT_STR,   5'd0};
            5'd22: s = '{5'd2,  4'd2, TT_STR,   5'd0};
            5'd23: s = '{5'd4,  4'd4, TT_STR,   5'd0};
            5'd24: s = '{5'd2,  4'd2, TT_ARRAY, 5'd0};
            5'd25: s = '{5'd4,  4'd4, TT_ARRAY, 5'd0};
            5'd26: s = '{5'd2,  4'd2, TT_MAP,   5'd0};
            5'd27: s = '{5'd4,  4'd4, TT_MAP,   5'd0};
            default: s = '{5'd0, 4'd0, TT_UNKNOWN, 5'd0};
        endcase
        return s;
    endfunction

endpackage

// ----- rtl/mtp_front.sv -----
// Front end: classifies each incoming byte as if it were a lead byte.
// Depends on mtp_pkg.
module mtp_front (
    input  logic [1:0]    op,
    input  logic [7:0]    data_byte,
    output mtp_pkg::cls_t cls
);

    // Lead byte decode
    always_comb begin
        cls          = '0;
        cls.op       = op;
        cls.data     = data_byte;
        cls.imm      = 1'b1;
        cls.imm_type = mtp_pkg::TT_UNKNOWN;
        if (data_byte <= mtp_pkg::LEAD_POS_MAX) begin
            cls.imm_type = mtp_pkg::TT_UINT;
            cls.imm_val  = data_byte;
        end else if (data_byte >= mtp_pkg::LEAD_NEG_MIN) begin
            cls.imm_type = mtp_pkg::TT_INT;
            cls.imm_val  = data_byte;
            cls.imm_neg  = 1'b1;
        end else if ((data_byte & mtp_pkg::LEAD_FIX_MASK) == mtp_pkg::LEAD_FIXMAP) begin
            cls.imm_type = mtp_pkg::TT_MAP;
            cls.imm_val  = data_byte & mtp_pkg::MASK_LO4;
        end else if ((data_byte & mtp_pkg::LEAD_FIX_MASK) == mtp_pkg::LEAD_FIXARR) begin
            cls.imm_type = mtp_pkg::TT_ARRAY;
            cls.imm_val  = data_byte & mtp_pkg::MASK_LO4;
        end else if ((data_byte & mtp_pkg::LEAD_STR_MASK) == mtp_pkg::LEAD_FIXSTR) begin
            cls.imm_type = mtp_pkg::TT_STR;
            cls.imm_val  = data_byte & mtp_pkg::MASK_LO5;
        end else if (data_byte == mtp_pkg::LEAD_NIL) begin
            cls.imm_type = mtp_pkg::TT_NIL;
        end else if (data_byte == mtp_pkg::LEAD_INVALID) begin
            cls.imm = 1'b0;
            cls.bad = 1'b1;
        end else if (data_byte == mtp_pkg::LEAD_FALSE) begin
            cls.imm_type = mtp_pkg::TT_BOOL;
        end else if (data_byte == mtp_pkg::LEAD_TRUE) begin
            cls.imm_type = mtp_pkg::TT_BOOL;
            cls.imm_val  = 8'd1;
        end else begin
            cls.imm   = 1'b0;
            cls.sized = 1'b1;
        end
    end

endmodule

// ----- rtl/mtp_queue.sv -----
// Short queue of classified words between front and back.
// Depends on mtp_pkg.
module mtp_queue #(
    parameter int unsigned DEPTH = mtp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  mtp_pkg::cls_t wr_data,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output mtp_pkg::cls_t rd_data
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    mtp_pkg::cls_t    mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- rtl/mtp_back.sv -----
// Back end: header state, trailing byte accumulation and the result register.
// Depends on mtp_pkg.
module mtp_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_empty,
    input  mtp_pkg::cls_t q_data,
    output logic          q_pop,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [3:0]    m_tag_type,
    output logic [63:0]   m_tag_value,
    output logic          m_parse_error
);

    logic [7:0]  lead_reg,  lead_next;
    logic [4:0]  left_reg,  left_next;
    logic [63:0] acc_reg,   acc_next;
    logic        err_reg,   err_next;
    logic        ovalid_reg, ovalid_next;
    logic [3:0]  otype_reg, otype_next;
    logic [63:0] oval_reg,  oval_next;
    logic        oerr_reg,  oerr_next;

    logic            emit;
    logic [4:0]      cur_idx;
    mtp_pkg::sized_t cur_info;
    logic [4:0]      lead_idx;
    mtp_pkg::sized_t lead_info;
    logic [4:0]      pos;
    logic [63:0]     acc_upd;
    logic [63:0]     fin_val;
    logic [4:0]      left_dec;

    assign q_pop         = !q_empty && (!ovalid_reg || m_ready);
    assign m_valid       = ovalid_reg;
    assign m_tag_type    = otype_reg;
    assign m_tag_value   = oval_reg;
    assign m_parse_error = oerr_reg;

    // Table lookups for the stored lead and for the byte as a new lead
    assign cur_idx   = 5'(lead_reg - mtp_pkg::LEAD_SIZED);
    assign cur_info  = mtp_pkg::sized_info(cur_idx);
    assign lead_idx  = 5'(q_data.data - mtp_pkg::LEAD_SIZED);
    assign lead_info = mtp_pkg::sized_info(lead_idx);
    assign pos       = cur_info.total - left_reg;
    assign left_dec  = left_reg - 5'd1;
    assign acc_upd   = (pos < 5'(cur_info.vbytes)) ? {acc_reg[55:0], q_data.data} : acc_reg;

    // Final value of a sized header
    always_comb begin
        fin_val = acc_upd;
        if (cur_info.vbytes == 4'd0) begin
            fin_val = 64'(cur_info.fixed);
        end else if (cur_info.ttype == mtp_pkg::TT_INT) begin
            unique case (cur_info.vbytes)
                4'd1:    fin_val = {{56{acc_upd[7]}},  acc_upd[7:0]};
                4'd2:    fin_val = {{48{acc_upd[15]}}, acc_upd[15:0]};
                4'd4:    fin_val = {{32{acc_upd[31]}}, acc_upd[31:0]};
                default: fin_val = acc_upd;
            endcase
        end
    end

    // Header state machine
    always_comb begin
        lead_next   = lead_reg;
        left_next   = left_reg;
        acc_next    = acc_reg;
        err_next    = err_reg;
        ovalid_next = ovalid_reg && !m_ready;
        otype_next  = otype_reg;
        oval_next   = oval_reg;
        oerr_next   = oerr_reg;
        emit        = 1'b0;

        if (q_pop) begin
            if (q_data.op == mtp_pkg::OP_RESTART) begin
                lead_next = '0;
                left_next = '0;
                acc_next  = '0;
                err_next  = 1'b0;
            end else if (q_data.op == mtp_pkg::OP_END && !err_reg) begin
                if (left_reg != '0) begin
                    emit = 1'b1;
                    oerr_next = 1'b1;
                end
            end else if (q_data.op == mtp_pkg::OP_DATA && !err_reg) begin
                if (left_reg != '0) begin
                    if (cur_idx >= 5'(mtp_pkg::SIZED_COUNT)) begin
                        emit      = 1'b1;
                        oerr_next = 1'b1;
                    end else begin
                        acc_next  = acc_upd;
                        left_next = left_dec;
                        if (left_dec == '0) begin
                            emit       = 1'b1;
                            acc_next   = '0;
                            otype_next = cur_info.ttype;
                            oval_next  = fin_val;
                            oerr_next  = 1'b0;
                        end
                    end
                end else begin
                    lead_next = q_data.data;
                    acc_next  = '0;
                    if (q_data.bad) begin
                        emit      = 1'b1;
                        oerr_next = 1'b1;
                    end else if (q_data.imm) begin
                        emit       = 1'b1;
                        otype_next = q_data.imm_type;
                        oval_next  = {{56{q_data.imm_neg}}, q_data.imm_val};
                        oerr_next  = 1'b0;
                    end else begin
                        left_next = lead_info.total;
                    end
                end
            end

            if (emit) begin
                ovalid_next = 1'b1;
                if (oerr_next) begin
                    err_next   = 1'b1;
                    left_next  = '0;
                    acc_next   = '0;
                    otype_next = mtp_pkg::TT_UNKNOWN;
                    oval_next  = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lead_reg   <= '0;
            left_reg   <= '0;
            acc_reg    <= '0;
            err_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            lead_reg   <= lead_next;
            left_reg   <= left_next;
            acc_reg    <= acc_next;
            err_reg    <= err_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Result payload, no reset
    always_ff @(posedge aclk) begin
        otype_reg <= otype_next;
        oval_reg  <= oval_next;
        oerr_reg  <= oerr_next;
    end

endmodule

// ----- rtl/msgpack_tag_header_parser.sv -----
// MessagePack tag header parser, top level: front classifier, queue, back end.
// An accepted byte passes the queue and the back end into the result register.
// Throughput: one byte per cycle unless a held result waits for m_tready.
// s_tready drops only when the queue is full; m_tvalid waits in a result register.
// Reset (aresetn low, synchronous) empties the queue and clears all header state.
// Depends on mtp_pkg, mtp_front, mtp_queue, mtp_back.
module msgpack_tag_header_parser #(
    parameter int unsigned QUEUE_DEPTH = mtp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_tuser,   // [1:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] tag_value
    output logic [4:0]  m_tuser    // [3:0] tag_type, [4] parse_error
);

    mtp_pkg::cls_t cls;
    mtp_pkg::cls_t q_data;
    logic          q_full;
    logic          q_empty;
    logic          q_pop;
    logic [3:0]    tag_type;
    logic [63:0]   tag_value;
    logic          parse_error;

    assign s_tready = !q_full;
    assign m_tdata  = tag_value;
    assign m_tuser  = {parse_error, tag_type};

    mtp_front u_front (
        .op        (s_tuser),
        .data_byte (s_tdata),
        .cls       (cls)
    );

    mtp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (s_tvalid && !q_full),
        .wr_data (cls),
        .full    (q_full),
        .pop     (q_pop),
        .empty   (q_empty),
        .rd_data (q_data)
    );

    mtp_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (q_empty),
        .q_data        (q_data),
        .q_pop         (q_pop),
        .m_valid       (m_tvalid),
        .m_ready       (m_tready),
        .m_tag_type    (tag_type),
        .m_tag_value   (tag_value),
        .m_parse_error (parse_error)
    );

endmodule

// ----- sim/tb_msgpack_tag_header_parser.sv -----
// Self-checking testbench for msgpack_tag_header_parser: directed table, then random tag streams.
// Expected words come from an in-bench tag decoder. Depends on mtp_pkg and the parser RTL.
module tb_msgpack_tag_header_parser;
    timeunit 1ns;
    timeprecision 1ps;

    // Op code 3 is reserved; the block must ignore it
    localparam logic [1:0] OP_RESERVED = 2'd3;
    localparam int ITEM_TARGET = 1950;
    localparam int IDLE_LIMIT  = 2000;
    localparam int TAIL_CYCLES = 20;
    localparam int MAX_PRINTS  = 50;

    typedef struct packed {
        logic [3:0]  ttype;
        logic [63:0] val;
        logic        err;
    } tag_rec_t;

    // Sized lead decode: trailing bytes, value bytes, tag type, fixext length
    typedef struct packed {
        logic [4:0] total;
        logic [3:0] vbytes;
        logic [3:0] ttype;
        logic [4:0] fixed;
    } hdr_form_t;

    typedef struct {
        logic [1:0] op;
        logic [7:0] b;
        bit         typed;
        tag_rec_t   rec;
    } dir_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;
    logic [1:0]  s_tuser  = mtp_pkg::OP_DATA;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [4:0]  m_tuser;

    msgpack_tag_header_parser DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] data_byte
        .s_tuser  (s_tuser),   // [1:0] op
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [63:0] tag_value
        .m_tuser  (m_tuser)    // [3:0] tag_type, [4] parse_error
    );

    always #10 aclk = ~aclk;

    // Decoder state mirrored in the bench
    logic [7:0]  cur_lead;
    logic [4:0]  bytes_left;
    logic [63:0] accum;
    bit          err_flag;

    tag_rec_t tag_q[$];
    tag_rec_t none_rec = '{mtp_pkg::TT_UNKNOWN, 64'd0, 1'b0};

    int fail_cnt    = 0;
    int tags_seen   = 0;
    int err_seen    = 0;
    int words_in    = 0;
    int items_done  = 0;
    int restarts    = 0;
    int burst_left  = 0;
    int idle_cnt    = 0;

    function automatic hdr_form_t sized_form(input logic [4:0] idx);
        hdr_form_t f;
        f = '0;
        if (idx <= 5'd2) begin
            f.ttype  = mtp_pkg::TT_BIN;
            f.vbytes = 4'd1 << idx;
            f.total  = {1'b0, f.vbytes};
        end else if (idx <= 5'd5) begin
            f.ttype  = mtp_pkg::TT_EXT;
            f.vbytes = 4'd1 << (idx - 5'd3);
            f.total  = {1'b0, f.vbytes} + 5'd1;   // ext type byte follows the length
        end else if (idx == 5'd6) begin
            f.ttype  = mtp_pkg::TT_F32;
            f.vbytes = 4'd4;
            f.total  = 5'd4;
        end else if (idx == 5'd7) begin
            f.ttype  = mtp_pkg::TT_F64;
            f.vbytes = 4'd8;
            f.total  = 5'd8;
        end else if (idx <= 5'd11) begin
            f.ttype  = mtp_pkg::TT_UINT;
            f.vbytes = 4'd1 << (idx - 5'd8);
            f.total  = {1'b0, f.vbytes};
        end else if (idx <= 5'd15) begin
            f.ttype  = mtp_pkg::TT_INT;
            f.vbytes = 4'd1 << (idx - 5'd12);
            f.total  = {1'b0, f.vbytes};
        end else if (idx <= 5'd20) begin
            // fixext: type byte plus a fixed payload, nothing accumulated
            f.ttype  = mtp_pkg::TT_EXT;
            f.fixed  = 5'd1 << (idx - 5'd16);
            f.total  = f.fixed + 5'd1;
        end else if (idx <= 5'd23) begin
            f.ttype  = mtp_pkg::TT_STR;
            f.vbytes = 4'd1 << (idx - 5'd21);
            f.total  = {1'b0, f.vbytes};
        end else if (idx <= 5'd25) begin
            f.ttype  = mtp_pkg::TT_ARRAY;
            f.vbytes = 4'd2 << (idx - 5'd24);
            f.total  = {1'b0, f.vbytes};
        end else if (idx <= 5'd27) begin
            f.ttype  = mtp_pkg::TT_MAP;
            f.vbytes = 4'd2 << (idx - 5'd26);
            f.total  = {1'b0, f.vbytes};
        end
        return f;
    endfunction

    function automatic void clear_decoder();
        cur_lead   = 8'd0;
        bytes_left = 5'd0;
        accum      = 64'd0;
        err_flag   = 1'b0;
    endfunction

    // Advance the decoder by one word; has is set when a tag word is due
    function automatic void decode_word(input logic [1:0] op, input logic [7:0] b,
                                        output bit has, output tag_rec_t rec);
        hdr_form_t   f;
        logic [7:0]  d;
        logic [4:0]  pos;
        logic [63:0] v;
        int          bits;
        has = 1'b0;
        rec = none_rec;
        if (op == mtp_pkg::OP_RESTART) begin
            clear_decoder();
        end else if (op == OP_RESERVED || err_flag) begin
            // ignored
        end else if (op == mtp_pkg::OP_END) begin
            if (bytes_left != 5'd0) begin
                err_flag   = 1'b1;
                bytes_left = 5'd0;
                accum      = 64'd0;
                has        = 1'b1;
                rec        = '{mtp_pkg::TT_UNKNOWN, 64'd0, 1'b1};
            end
        end else if (bytes_left != 5'd0) begin
            // trailing byte of a sized header
            d   = cur_lead - mtp_pkg::LEAD_SIZED;
            f   = sized_form(d[4:0]);
            pos = f.total - bytes_left;
            if (pos < {1'b0, f.vbytes})
                accum = {accum[55:0], b};
            bytes_left = bytes_left - 5'd1;
            if (bytes_left == 5'd0) begin
                if (f.vbytes == 4'd0) begin
                    v = {59'd0, f.fixed};
                end else begin
                    v = accum;
                    if (f.ttype == mtp_pkg::TT_INT && f.vbytes < 4'd8) begin
                        bits = int'(f.vbytes) * 8;
                        if (v[bits-1])
                            v = v | (~64'd0 << bits);
                    end
                end
                accum = 64'd0;
                has   = 1'b1;
                rec   = '{f.ttype, v, 1'b0};
            end
        end else begin
            // lead byte
            cur_lead = b;
            accum    = 64'd0;
            has      = 1'b1;
            if (b <= mtp_pkg::LEAD_POS_MAX)
                rec = '{mtp_pkg::TT_UINT, {56'd0, b}, 1'b0};
            else if (b >= mtp_pkg::LEAD_NEG_MIN)
                rec = '{mtp_pkg::TT_INT, {56'hff_ffff_ffff_ffff, b}, 1'b0};
            else if ((b & mtp_pkg::LEAD_FIX_MASK) == mtp_pkg::LEAD_FIXMAP)
                rec = '{mtp_pkg::TT_MAP, {56'd0, b & mtp_pkg::MASK_LO4}, 1'b0};
            else if ((b & mtp_pkg::LEAD_FIX_MASK) == mtp_pkg::LEAD_FIXARR)
                rec = '{mtp_pkg::TT_ARRAY, {56'd0, b & mtp_pkg::MASK_LO4}, 1'b0};
            else if ((b & mtp_pkg::LEAD_STR_MASK) == mtp_pkg::LEAD_FIXSTR)
                rec = '{mtp_pkg::TT_STR, {56'd0, b & mtp_pkg::MASK_LO5}, 1'b0};
            else if (b == mtp_pkg::LEAD_NIL)
                rec = '{mtp_pkg::TT_NIL, 64'd0, 1'b0};
            else if (b == mtp_pkg::LEAD_INVALID) begin
                err_flag   = 1'b1;
                bytes_left = 5'd0;
                rec        = '{mtp_pkg::TT_UNKNOWN, 64'd0, 1'b1};
            end else if (b == mtp_pkg::LEAD_FALSE)
                rec = '{mtp_pkg::TT_BOOL, 64'd0, 1'b0};
            else if (b == mtp_pkg::LEAD_TRUE)
                rec = '{mtp_pkg::TT_BOOL, 64'd1, 1'b0};
            else begin
                d          = b - mtp_pkg::LEAD_SIZED;
                f          = sized_form(d[4:0]);
                bytes_left = f.total;
                has        = 1'b0;
            end
        end
    endfunction

    task automatic report(input string msg);
        if (fail_cnt < MAX_PRINTS)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        fail_cnt++;
    endtask

    // Drive one word at the falling edge and hold it until accepted
    task automatic send_word(input logic [1:0] op, input logic [7:0] b,
                             input bit typed, input tag_rec_t want);
        bit       has;
        tag_rec_t rec;
        if (op == mtp_pkg::OP_RESTART || (op != OP_RESERVED && !err_flag))
            items_done++;
        if (op == mtp_pkg::OP_RESTART)
            restarts++;
        decode_word(op, b, has, rec);
        if (typed)
            tag_q.push_back(want);
        else if (has)
            tag_q.push_back(rec);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        words_in++;
        @(negedge aclk);
        // bursts with random gaps; occasionally a long gap-free stretch
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
            if ($urandom_range(0, 5) == 0)
                burst_left = $urandom_range(100, 300);
            else
                burst_left = $urandom_range(0, 40);
        end
    endtask

    // Lead byte of a sized form followed by n trailing bytes
    task automatic send_sized(input logic [7:0] lead, input int n);
        int         mode;
        logic [7:0] b;
        mode = $urandom_range(0, 5);
        send_word(mtp_pkg::OP_DATA, lead, 1'b0, none_rec);
        for (int i = 0; i < n; i++) begin
            case (mode)
                0: b = 8'hff;
                1: b = 8'h00;
                2: b = (i == 0) ? 8'h80 : 8'($urandom_range(0, 255));
                default: b = 8'($urandom_range(0, 255));
            endcase
            send_word(mtp_pkg::OP_DATA, b, 1'b0, none_rec);
        end
    endtask

    task automatic drain_tags();
        s_tvalid <= 1'b0;
        do
            @(negedge aclk);
        while (tag_q.size() != 0);
    endtask

    function automatic dir_row_t mk_row(input logic [1:0] op, input logic [7:0] b,
                                        input bit typed, input logic [3:0] tt,
                                        input logic [63:0] v, input logic e);
        dir_row_t r;
        r.op    = op;
        r.b     = b;
        r.typed = typed;
        r.rec   = '{tt, v, e};
        return r;
    endfunction

    // Receiver: ready follows a 16-bit pattern, redrawn every lap
    logic [15:0] rdy_pat = 16'hffff;
    logic [3:0]  rdy_pos = 4'd0;
    always @(negedge aclk) begin
        m_tready <= rdy_pat[rdy_pos];
        rdy_pos  <= rdy_pos + 4'd1;
        if (rdy_pos == 4'd15) begin
            case ($urandom_range(0, 3))
                0: rdy_pat <= 16'hffff;
                1: rdy_pat <= 16'($urandom) | 16'h8000;
                2: rdy_pat <= 16'($urandom | $urandom) | 16'h8000;
                default: rdy_pat <= 16'($urandom & $urandom) | 16'h8000;
            endcase
        end
    end

    // Result monitor: compare each accepted word with the oldest expected tag
    always @(posedge aclk) begin
        tag_rec_t got;
        tag_rec_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.ttype = m_tuser[3:0];
            got.val   = m_tdata;
            got.err   = m_tuser[4];
            tags_seen++;
            if (got.err)
                err_seen++;
            if (tag_q.size() == 0) begin
                report($sformatf("unexpected tag word type=%0d value=%h err=%0b",
                                 got.ttype, got.val, got.err));
            end else begin
                want = tag_q.pop_front();
                if (got.ttype !== want.ttype)
                    report($sformatf("tag_type %0d, want %0d", got.ttype, want.ttype));
                if (got.val !== want.val)
                    report($sformatf("tag_value %h, want %h", got.val, want.val));
                if (got.err !== want.err)
                    report($sformatf("parse_error %0b, want %0b", got.err, want.err));
            end
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cnt <= 0;
        end else begin
            idle_cnt <= idle_cnt + 1;
            if (idle_cnt >= IDLE_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Stimulus
    initial begin
        dir_row_t   rows[$];
        int         r;
        int         n;
        int         next_drain;
        logic [7:0] b;
        logic [7:0] lead;
        hdr_form_t  f;

        clear_decoder();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: immediate forms at their extremes, sized forms, errors, restart
        rows.push_back(mk_row(mtp_pkg::OP_DATA, 8'h00, 1, mtp_pkg::TT_UINT, 64'd0, 1'b0));
        rows.push_back(mk_row(mtp_pkg::OP_DATA, 8'h7f, 1, mtp_pkg::TT_UINT, 64'd127, 1'b0));
        rows.push_back(mk_row(mtp_pkg::OP_DATA, 8'he0, 1, mtp_pkg::TT_INT,
                              64'hffff_ffff_ffff_ffe0, 1'b0));
        rows.push_back(mk_row(mtp_pkg::OP_DATA, 8'hff, 1, mtp_pkg::TT_INT, ~64'd0, 1'b0));
        rows.push_back(mk_row(mtp_pkg::OP_DATA, 8'h8f, 1, mtp_pkg::TT_MAP, 64'd15, 1'b0));
        rows.push_back(mk_row(mtp_pkg::OP_DATA, 8'h90, 1, mtp_pkg::TT_ARRAY, 64'd0, 1'b0));
        rows.push_back(mk_row(mtp_pkg::OP_DATA, 8'hbf, 1, mtp_pkg::TT_STR, 64'd31, 1'b0));
        rows.push_back(mk_row(mtp_pkg::OP_DATA, 8'hc0, 1, mtp_pkg::TT_NIL, 64'd0, 1'b0));
        rows.push_back(mk_row(mtp_pkg::OP_DATA, 8'hc2, 1, mtp_pkg::TT_BOOL, 64'd0, 1'b0));
        rows.push_back(mk_row(mtp_pkg::OP_DATA, 8'hc3, 1, mtp_pkg::TT_BOOL, 64'd1, 1'b0));
        // end of buffer between tags and a reserved op: no word
        rows.push_back(mk_row(mtp_pkg::OP_END, 8'h00, 0, mtp_pkg::TT_UNKNOWN, 64'd0, 1'b0));
        rows.push_back(mk_row(OP_RESERVED, 8'hff, 0, mtp_pkg::TT_UNKNOWN, 64'd0, 1'b0));
        // int8 -128, sign extended
        rows.push_back(mk_row(mtp_pkg::OP_DATA, 8'hd0, 0, mtp_pkg::TT_UNKNOWN, 64'd0, 1'b0));
        rows.push_back(mk_row(mtp_pkg::OP_DATA, 8'h80, 1, mtp_pkg::TT_INT,
                              64'hffff_ffff_ffff_ff80, 1'b0));
        // fixext1: type and payload skipped
        rows.push_back(mk_row(mtp_pkg::OP_DATA, 8'hd4, 0, mtp_pkg::TT_UNKNOWN, 64'd0, 1'b0));
        rows.push_back(mk_row(mtp_pkg::OP_DATA, 8'h12, 0, mtp_pkg::TT_UNKNOWN, 64'd0, 1'b0));
        rows.push_back(mk_row(mtp_pkg::OP_DATA, 8'h34, 0, mtp_pkg::TT_UNKNOWN, 64'd0, 1'b0));
        // ext8: length kept, type byte dropped
        rows.push_back(mk_row(mtp_pkg::OP_DATA, 8'hc7, 0, mtp_pkg::TT_UNKNOWN, 64'd0, 1'b0));
        rows.push_back(mk_row(mtp_pkg::OP_DATA, 8'h05, 0, mtp_pkg::TT_UNKNOWN, 64'd0, 1'b0));
        rows.push_back(mk_row(mtp_pkg::OP_DATA, 8'h01, 0, mtp_pkg::TT_UNKNOWN, 64'd0, 1'b0));
        // str8 cut short by end of buffer, then ignored until restart
        rows.push_back(mk_row(mtp_pkg::OP_DATA, 8'hd9, 0, mtp_pkg::TT_UNKNOWN, 64'd0, 1'b0));
        rows.push_back(mk_row(mtp_pkg::OP_END, 8'h00, 1, mtp_pkg::TT_UNKNOWN, 64'd0, 1'b1));
        rows.push_back(mk_row(mtp_pkg::OP_DATA, 8'h00, 0, mtp_pkg::TT_UNKNOWN, 64'd0, 1'b0));
        rows.push_back(mk_row(mtp_pkg::OP_RESTART, 8'h00, 0, mtp_pkg::TT_UNKNOWN,
                              64'd0, 1'b0));
        // invalid lead
        rows.push_back(mk_row(mtp_pkg::OP_DATA, 8'hc1, 1, mtp_pkg::TT_UNKNOWN, 64'd0, 1'b1));
        rows.push_back(mk_row(mtp_pkg::OP_RESTART, 8'hff, 0, mtp_pkg::TT_UNKNOWN,
                              64'd0, 1'b0));
        foreach (rows[i])
            send_word(rows[i].op, rows[i].b, rows[i].typed, rows[i].rec);

        // Random: mostly well-formed tags, plus cut headers, errors and noise
        next_drain = items_done + $urandom_range(200, 500);
        while (items_done < ITEM_TARGET) begin
            if (err_flag) begin
                // a few ignored words, then restart
                repeat ($urandom_range(0, 3)) begin
                    case ($urandom_range(0, 2))
                        0: send_word(mtp_pkg::OP_DATA, 8'($urandom_range(0, 255)),
                                     1'b0, none_rec);
                        1: send_word(mtp_pkg::OP_END, 8'($urandom_range(0, 255)),
                                     1'b0, none_rec);
                        default: send_word(OP_RESERVED, 8'($urandom_range(0, 255)),
                                           1'b0, none_rec);
                    endcase
                end
                send_word(mtp_pkg::OP_RESTART, 8'($urandom_range(0, 255)), 1'b0, none_rec);
                continue;
            end
            r = $urandom_range(0, 99);
            if (r < 60) begin
                if ($urandom_range(0, 1) == 0) begin
                    lead = mtp_pkg::LEAD_SIZED
                         + 8'($urandom_range(0, mtp_pkg::SIZED_COUNT - 1));
                    f    = sized_form(5'(lead - mtp_pkg::LEAD_SIZED));
                    send_sized(lead, int'(f.total));
                end else begin
                    do
                        b = 8'($urandom_range(0, 255));
                    while (b == mtp_pkg::LEAD_INVALID
                           || (b >= mtp_pkg::LEAD_SIZED && b <= 8'hdf));
                    send_word(mtp_pkg::OP_DATA, b, 1'b0, none_rec);
                end
            end else if (r < 66) begin
                send_word(mtp_pkg::OP_END, 8'($urandom_range(0, 255)), 1'b0, none_rec);
            end else if (r < 73) begin
                // header cut short by end of buffer or by restart
                lead = mtp_pkg::LEAD_SIZED
                     + 8'($urandom_range(0, mtp_pkg::SIZED_COUNT - 1));
                f    = sized_form(5'(lead - mtp_pkg::LEAD_SIZED));
                n    = $urandom_range(0, int'(f.total) - 1);
                send_sized(lead, n);
                if ($urandom_range(0, 2) == 0)
                    send_word(mtp_pkg::OP_RESTART, 8'($urandom_range(0, 255)),
                              1'b0, none_rec);
                else
                    send_word(mtp_pkg::OP_END, 8'($urandom_range(0, 255)), 1'b0, none_rec);
            end else if (r < 76) begin
                send_word(mtp_pkg::OP_DATA, mtp_pkg::LEAD_INVALID, 1'b0, none_rec);
            end else if (r < 80) begin
                send_word(mtp_pkg::OP_RESTART, 8'($urandom_range(0, 255)), 1'b0, none_rec);
            end else if (r < 83) begin
                send_word(OP_RESERVED, 8'($urandom_range(0, 255)), 1'b0, none_rec);
            end else begin
                send_word(mtp_pkg::OP_DATA, 8'($urandom_range(0, 255)), 1'b0, none_rec);
            end
            // hold off now and then until every pending tag has come out
            if (items_done >= next_drain) begin
                drain_tags();
                next_drain = items_done + $urandom_range(200, 500);
            end
        end

        // Wind down
        drain_tags();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (tag_q.size() != 0)
            report($sformatf("%0d expected tag words never arrived", tag_q.size()));
        $display("Summary: %0d words driven, %0d counted items, %0d restarts",
                 words_in, items_done, restarts);
        $display("Summary: %0d tag words checked, %0d of them error reports, %0d mismatches",
                 tags_seen, err_seen, fail_cnt);
        if (fail_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/mtp_pkg.sv
rtl/mtp_front.sv
rtl/mtp_queue.sv
rtl/mtp_back.sv
rtl/msgpack_tag_header_parser.sv
sim/tb_msgpack_tag_header_parser.sv
